// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker of the merge block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled at the rising clock edge, off while reset is low.
`define SRKM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("srkm assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define SRKM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("srkm assertion failed");

`endif

// ===== hw/rtl/srkm_pkg.sv =====
// Shared constants, types and codes of the sorted-run k-way merge block.
// No dependencies.
package srkm_pkg;

  localparam int NUM_RUNS  = 8;
  localparam int RUN_DEPTH = 1024;

  localparam int RUN_W   = $clog2(NUM_RUNS);
  localparam int POS_W   = $clog2(RUN_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_RUNS * RUN_DEPTH);
  localparam int STORE_DEPTH = NUM_RUNS * RUN_DEPTH;

  localparam int HALF_W   = 64;
  localparam int KEY_W    = 2 * HALF_W;
  localparam int RUN_ID_W = 3;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = ((RUN_ID_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KEY_W + RUN_ID_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef logic [RUN_W-1:0]  run_idx_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [KEY_W-1:0]  key_t;

  // Access to the run bookkeeping table: one entry selected per cycle.
  typedef struct packed {
    logic     clear;
    logic     fill_inc;
    logic     pos_inc;
    run_idx_t idx;
  } run_tbl_op_t;

endpackage

// ===== hw/rtl/sorted_run_kway_merge.sv =====
// Top level of the sorted-run k-way merge: command decode, head scan, result register.
// Depends on srkm_pkg, srkm_key_ram, srkm_run_table.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  s_axis  | in  | run_id[2:0] key_high[66:3] key_low   | cmd[1:0]
//  m_axis  | out | out_high[63:0] out_low from_run      | status[2:0]
//
// Append and clear: after the accept the block passes through the result state, then takes the next item.
// Pop: the head of every nonempty run is read through the single key RAM read
// port, one run per cycle, and compared against the running best.
// Reset clears the run counters at once; the key RAM needs no sweep.
// A result waits in the output register while the next item is taken; a
// further result holds the block until the output register frees up.
module sorted_run_kway_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // run_id[2:0], key_high[66:3], key_low[130:67], zero pad
  input  logic [srkm_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // cmd[1:0]
  input  logic [srkm_pkg::CMD_W-1:0]           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // out_high[63:0], out_low[127:64], from_run[130:128], zero pad
  output logic [srkm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // status[2:0]
  output logic [srkm_pkg::STATUS_W-1:0]        m_axis_tuser_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // input fields
  logic [srkm_pkg::CMD_W-1:0]    in_cmd;
  logic [srkm_pkg::RUN_ID_W-1:0] in_run;
  logic [srkm_pkg::HALF_W-1:0]   in_key_high, in_key_low;
  srkm_pkg::run_idx_t            in_idx;

  assign in_cmd      = s_axis_tuser_i;
  assign in_run      = s_axis_tdata_i[srkm_pkg::RUN_ID_W-1:0];
  assign in_key_high = s_axis_tdata_i[srkm_pkg::RUN_ID_W +: srkm_pkg::HALF_W];
  assign in_key_low  = s_axis_tdata_i[srkm_pkg::RUN_ID_W + srkm_pkg::HALF_W +: srkm_pkg::HALF_W];
  assign in_idx      = srkm_pkg::run_idx_t'(in_run);

  logic s_accept;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // scan and result registers
  srkm_pkg::run_idx_t scan_q, scan_d;
  logic               found_q, found_d;
  logic               rd_pend_q, rd_pend_d;
  srkm_pkg::run_idx_t rd_run_q, rd_run_d;
  srkm_pkg::run_idx_t best_run_q, best_run_d;
  srkm_pkg::key_t     best_key_q, best_key_d;
  srkm_pkg::key_t     res_key_q, res_key_d;
  logic [srkm_pkg::RUN_ID_W-1:0] res_run_q, res_run_d;
  logic [srkm_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                          m_valid_q, m_valid_d;
  logic [srkm_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic [srkm_pkg::STATUS_W-1:0]    m_user_q, m_user_d;

  // run table
  srkm_pkg::run_tbl_op_t tbl_op;
  srkm_pkg::pos_t        tbl_fill, tbl_pos;

  srkm_run_table u_run_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (tbl_op),
    .fill_o (tbl_fill),
    .pos_o  (tbl_pos)
  );

  logic run_ok, run_full, append_ok, nonempty;
  assign run_ok    = int'(in_run) < srkm_pkg::NUM_RUNS;
  assign run_full  = tbl_fill >= srkm_pkg::pos_t'(srkm_pkg::RUN_DEPTH);
  assign append_ok = s_accept && (in_cmd == srkm_pkg::CMD_APPEND) && run_ok && !run_full;
  assign nonempty  = tbl_pos < tbl_fill;

  // key RAM: write on append, head read during the scan
  srkm_pkg::run_idx_t addr_run;
  srkm_pkg::pos_t     addr_pos;
  srkm_pkg::addr_t    ram_addr;
  srkm_pkg::key_t     ram_rdata;
  logic               ram_re;

  assign addr_run = (state_q == S_SCAN) ? scan_q : in_idx;
  assign addr_pos = (state_q == S_SCAN) ? tbl_pos : tbl_fill;
  assign ram_addr = srkm_pkg::addr_t'(addr_run) * srkm_pkg::addr_t'(srkm_pkg::RUN_DEPTH)
                  + srkm_pkg::addr_t'(addr_pos);
  assign ram_re   = (state_q == S_SCAN) && nonempty;

  srkm_key_ram #(
    .Depth (srkm_pkg::STORE_DEPTH),
    .Width (srkm_pkg::KEY_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (append_ok),
    .waddr_i (ram_addr),
    .wdata_i ({in_key_high, in_key_low}),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // head just read beats the best so far; ties keep the lower run
  logic               take;
  logic               pop_found;
  srkm_pkg::run_idx_t pop_run;
  srkm_pkg::key_t     pop_key;

  assign take      = rd_pend_q && (!found_q || (ram_rdata < best_key_q));
  assign pop_found = found_q || rd_pend_q;
  assign pop_run   = take ? rd_run_q : best_run_q;
  assign pop_key   = take ? ram_rdata : best_key_q;

  always_comb begin
    tbl_op          = '0;
    tbl_op.idx      = in_idx;
    case (state_q)
      S_IDLE: begin
        tbl_op.clear    = s_accept && (in_cmd == srkm_pkg::CMD_CLEAR);
        tbl_op.fill_inc = append_ok;
      end
      S_SCAN: begin
        tbl_op.idx = scan_q;
      end
      S_LAST: begin
        tbl_op.idx     = pop_run;
        tbl_op.pos_inc = pop_found;
      end
      default: begin
        tbl_op.idx = in_idx;
      end
    endcase
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    found_d      = found_q;
    rd_pend_d    = rd_pend_q;
    rd_run_d     = rd_run_q;
    best_run_d   = best_run_q;
    best_key_d   = best_key_q;
    res_key_d    = res_key_q;
    res_run_d    = res_run_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          res_key_d = '0;
          res_run_d = '0;
          case (in_cmd)
            srkm_pkg::CMD_APPEND: begin
              res_status_d = append_ok ? srkm_pkg::ST_APPENDED : srkm_pkg::ST_FULL;
              state_d      = S_RESULT;
            end
            srkm_pkg::CMD_POP: begin
              scan_d    = '0;
              found_d   = 1'b0;
              rd_pend_d = 1'b0;
              state_d   = S_SCAN;
            end
            srkm_pkg::CMD_CLEAR: begin
              res_status_d = srkm_pkg::ST_CLEARED;
              state_d      = S_RESULT;
            end
            default: begin
              state_d = S_IDLE;  // reserved command: no result
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          found_d    = 1'b1;
          best_run_d = rd_run_q;
          best_key_d = ram_rdata;
        end
        rd_pend_d = nonempty;
        rd_run_d  = scan_q;
        scan_d    = scan_q + 1'b1;
        if (scan_q == srkm_pkg::run_idx_t'(srkm_pkg::NUM_RUNS - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (pop_found) begin
          res_key_d    = pop_key;
          res_run_d    = srkm_pkg::RUN_ID_W'(pop_run);
          res_status_d = srkm_pkg::ST_POPPED;
        end else begin
          res_key_d    = '0;
          res_run_d    = '0;
          res_status_d = srkm_pkg::ST_EMPTY;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = srkm_pkg::OUT_TDATA_W'({res_run_q,
                                              res_key_q[srkm_pkg::HALF_W-1:0],
                                              res_key_q[srkm_pkg::KEY_W-1:srkm_pkg::HALF_W]});
          m_user_d  = res_status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      found_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      found_q   <= found_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_run_q     <= rd_run_d;
    best_run_q   <= best_run_d;
    best_key_q   <= best_key_d;
    res_key_q    <= res_key_d;
    res_run_q    <= res_run_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== hw/rtl/srkm_key_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module srkm_key_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/srkm_run_table.sv =====
// Per-run fill counts and read positions of the merge block.
// Depends on srkm_pkg.
module srkm_run_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srkm_pkg::run_tbl_op_t op_i,
  output srkm_pkg::pos_t        fill_o,
  output srkm_pkg::pos_t        pos_o
);

  srkm_pkg::pos_t fill_q [srkm_pkg::NUM_RUNS];
  srkm_pkg::pos_t pos_q  [srkm_pkg::NUM_RUNS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srkm_pkg::NUM_RUNS; i++) begin
        fill_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else if (op_i.clear) begin
      for (int i = 0; i < srkm_pkg::NUM_RUNS; i++) begin
        fill_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      if (op_i.fill_inc) begin
        fill_q[op_i.idx] <= fill_q[op_i.idx] + 1'b1;
      end
      if (op_i.pos_inc) begin
        pos_q[op_i.idx] <= pos_q[op_i.idx] + 1'b1;
      end
    end
  end

  assign fill_o = fill_q[op_i.idx];
  assign pos_o  = pos_q[op_i.idx];

endmodule

// ===== hw/rtl/srkm_checker.sv =====
// Port-level checker of the merge block, bound to the top level.
// Depends on srkm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srkm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic [srkm_pkg::CMD_W-1:0]           s_axis_tuser_i,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [srkm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input logic [srkm_pkg::STATUS_W-1:0]        m_axis_tuser_o
);

  logic out_stall;
  logic cmd_accept;
  logic no_key;

  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign cmd_accept = s_axis_tvalid_i && s_axis_tready_o
                   && (s_axis_tuser_i == srkm_pkg::CMD_APPEND
                    || s_axis_tuser_i == srkm_pkg::CMD_POP
                    || s_axis_tuser_i == srkm_pkg::CMD_CLEAR);
  assign no_key     = m_axis_tvalid_o && (m_axis_tuser_o != srkm_pkg::ST_POPPED);

  `SRKM_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_stall, m_axis_tvalid_o)
  `SRKM_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o))
  // only a popped key carries data
  `SRKM_ASSERT(a_zero_unless_popped, clk_i, rst_ni, no_key |-> (m_axis_tdata_o == '0))
  // every real command closes the input in the next cycle
  `SRKM_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni, cmd_accept, !s_axis_tready_o)

endmodule

bind sorted_run_kway_merge srkm_checker u_srkm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
